>>> rtl/core/hcfp_pkg.sv
`timescale 1ns / 1ps

package hcfp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_WRITE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_READ  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_ERASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_JUMP  = 3'd4;

   localparam logic [15:0] POLY_RESET     = 16'hA001;
   localparam logic [7:0]  OP_WRITE_RESET = 8'h01;
   localparam logic [7:0]  OP_READ_RESET  = 8'h02;
   localparam logic [7:0]  OP_ERASE_RESET = 8'h03;
   localparam logic [7:0]  OP_JUMP_RESET  = 8'h04;

   // Result status codes
   localparam logic [2:0] STATUS_FAIL  = 3'd0;
   localparam logic [2:0] STATUS_WRITE = 3'd1;
   localparam logic [2:0] STATUS_READ  = 3'd2;
   localparam logic [2:0] STATUS_ERASE = 3'd3;
   localparam logic [2:0] STATUS_JUMP  = 3'd4;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  command_byte;
      logic [31:0] target_address;
      logic [7:0]  count_byte;
      logic        crc_ok;
   } rsp_type;

   typedef struct packed {
      logic [15:0] crc_poly;
      logic [7:0]  op_write;
      logic [7:0]  op_read;
      logic [7:0]  op_erase;
      logic [7:0]  op_jump;
   } cfg_type;

endpackage

>>> rtl/core/hcfp_csr.sv
`timescale 1ns / 1ps

module hcfp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [hcfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hcfp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output hcfp_pkg::cfg_type                  cfg
);

   hcfp_pkg::cfg_type cfg_ff;
   hcfp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hcfp_pkg::CSR_POLY:     cfg_in.crc_poly = csr_wdata;
            hcfp_pkg::CSR_OP_WRITE: cfg_in.op_write = csr_wdata[7:0];
            hcfp_pkg::CSR_OP_READ:  cfg_in.op_read  = csr_wdata[7:0];
            hcfp_pkg::CSR_OP_ERASE: cfg_in.op_erase = csr_wdata[7:0];
            hcfp_pkg::CSR_OP_JUMP:  cfg_in.op_jump  = csr_wdata[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly <= hcfp_pkg::POLY_RESET;
         cfg_ff.op_write <= hcfp_pkg::OP_WRITE_RESET;
         cfg_ff.op_read  <= hcfp_pkg::OP_READ_RESET;
         cfg_ff.op_erase <= hcfp_pkg::OP_ERASE_RESET;
         cfg_ff.op_jump  <= hcfp_pkg::OP_JUMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/hcfp_crc_byte.sv
`timescale 1ns / 1ps

module hcfp_crc_byte (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   input  logic [15:0] poly,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      // Eight reflected shift steps, LSB first
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ poly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

>>> rtl/core/hcfp_parse.sv
`timescale 1ns / 1ps

module hcfp_parse (
   input  logic                clock,
   input  logic                reset,
   input  hcfp_pkg::cfg_type   cfg,
   input  logic                item_valid,
   input  hcfp_pkg::req_type   item,
   output logic                emit,
   output hcfp_pkg::rsp_type   result
);

   localparam logic [7:0]  StartChar = 8'h7E;
   localparam logic [15:0] CrcInit   = 16'hFFFF;
   localparam logic [4:0]  CmdPos    = 5'd2;
   localparam logic [4:0]  AddrEnd   = 5'd10;
   localparam logic [4:0]  HexEnd    = 5'd12;
   localparam logic [4:0]  LastPos   = 5'd16;

   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] rxcrc_ff, rxcrc_in;
   logic [15:0] crc_ff, crc_in;
   logic [3:0]  nib_ff, nib_in;
   logic        decided_ff, decided_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [7:0]  full_byte;
   logic [7:0]  crc_data;
   logic [15:0] crc_next;
   logic        crc_match;
   logic [2:0]  status_w;
   logic        ok_w;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      if (item.char_in >= "0" && item.char_in <= "9") begin
         hex_val = 4'(item.char_in - "0");
      end else if (item.char_in >= "a" && item.char_in <= "f") begin
         hex_val = 4'(item.char_in - "a" + 8'd10);
      end else if (item.char_in >= "A" && item.char_in <= "F") begin
         hex_val = 4'(item.char_in - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign full_byte = {nib_ff, hex_val};
   assign crc_data  = (pos_ff == 5'd0) ? StartChar : full_byte;

   hcfp_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (crc_data),
      .poly      (cfg.crc_poly),
      .crc_next  (crc_next)
   );

   assign crc_match = ({rxcrc_ff[11:0], hex_val} == crc_ff);

   always_comb begin
      pos_in     = pos_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      rxcrc_in   = rxcrc_ff;
      crc_in     = crc_ff;
      nib_in     = nib_ff;
      decided_in = decided_ff;
      emit       = 1'b0;
      status_w   = hcfp_pkg::STATUS_FAIL;
      ok_w       = 1'b0;

      if (!decided_ff) begin
         if (pos_ff == 5'd0) begin
            if (item.char_in != StartChar) begin
               emit       = 1'b1;
               decided_in = 1'b1;
            end else begin
               crc_in = crc_next;
            end
         end else if (!hex_ok) begin
            emit       = 1'b1;
            decided_in = 1'b1;
         end else if (pos_ff <= HexEnd) begin
            if (pos_ff[0]) begin
               nib_in = hex_val;
            end else begin
               if (pos_ff == CmdPos) begin
                  cmd_in = full_byte;
               end else if (pos_ff <= AddrEnd) begin
                  addr_in = {addr_ff[23:0], full_byte};
               end else begin
                  data_in = full_byte;
               end
               crc_in = crc_next;
            end
         end else begin
            rxcrc_in = {rxcrc_ff[11:0], hex_val};
            if (pos_ff == LastPos) begin
               emit       = 1'b1;
               decided_in = 1'b1;
               ok_w       = crc_match;
               if (crc_match) begin
                  if (cmd_ff == cfg.op_write) begin
                     status_w = hcfp_pkg::STATUS_WRITE;
                  end else if (cmd_ff == cfg.op_read) begin
                     status_w = hcfp_pkg::STATUS_READ;
                  end else if (cmd_ff == cfg.op_erase) begin
                     status_w = hcfp_pkg::STATUS_ERASE;
                  end else if (cmd_ff == cfg.op_jump) begin
                     status_w = hcfp_pkg::STATUS_JUMP;
                  end
               end
            end
         end

         if (!decided_in && pos_ff < LastPos) begin
            pos_in = pos_ff + 5'd1;
         end
         // Buffer ended before the frame was decided
         if (!decided_in && item.end_of_buffer) begin
            emit       = 1'b1;
            decided_in = 1'b1;
         end
      end

      result.status         = status_w;
      result.command_byte   = cmd_in;
      result.target_address = addr_in;
      result.count_byte     = data_in;
      result.crc_ok         = ok_w;

      // Rearm for the next buffer
      if (item.end_of_buffer) begin
         pos_in     = 5'd0;
         cmd_in     = 8'h00;
         addr_in    = 32'h0;
         data_in    = 8'h00;
         rxcrc_in   = 16'h0;
         crc_in     = CrcInit;
         nib_in     = 4'h0;
         decided_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 5'd0;
         cmd_ff     <= 8'h00;
         addr_ff    <= 32'h0;
         data_ff    <= 8'h00;
         rxcrc_ff   <= 16'h0;
         crc_ff     <= CrcInit;
         nib_ff     <= 4'h0;
         decided_ff <= 1'b0;
      end else if (item_valid) begin
         pos_ff     <= pos_in;
         cmd_ff     <= cmd_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         rxcrc_ff   <= rxcrc_in;
         crc_ff     <= crc_in;
         nib_ff     <= nib_in;
         decided_ff <= decided_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos)
      else $error("character position beyond frame end");

   a_pass_has_crc: assert property (@(posedge clock) disable iff (reset)
      item_valid && emit && result.status != hcfp_pkg::STATUS_FAIL |-> result.crc_ok)
      else $error("command accepted without CRC match");

   a_quiet_after_decision: assert property (@(posedge clock) disable iff (reset)
      item_valid && decided_ff |-> !emit)
      else $error("second result within one buffer");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.end_of_buffer |=> pos_ff == 5'd0 && !decided_ff && crc_ff == CrcInit)
      else $error("parser not rearmed after end of buffer");

endmodule

>>> rtl/core/hex_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  hcfp_pkg::req_type (char_in, end_of_buffer)
// rsp      out        rsp_valid/rsp_ready  hcfp_pkg::rsp_type (status .. crc_ok)
// csr      in         csr_we               csr_index, csr_wdata (write only)
//
// One character a cycle sustained while the result is not stalled; a transaction is held
// in the input register, then its result in the result register, where rsp_valid rises.
// Datapath: input register, then decode and one CRC byte update into the result register.
// Reset is synchronous and active high; it restores the registers and rearms the parser.
// A stalled result holds in its register; the input register still takes a new
// transaction and holds it until the result register frees.

module hex_command_frame_parser_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hcfp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hcfp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [hcfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hcfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   hcfp_pkg::cfg_type cfg;
   hcfp_pkg::req_type in_ff, in_in;
   logic              in_valid_ff, in_valid_in;
   hcfp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              advance;
   logic              emit;
   hcfp_pkg::rsp_type result;

   hcfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   hcfp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item       (in_ff),
      .emit       (emit),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         // drop the delivered transaction
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hcfp_pkg::*;

   localparam logic [7:0] START_CHAR    = 8'h7E;
   localparam logic [4:0] LAST_POS      = 5'd16;
   localparam int         SETTLE_CYCLES = 6;
   localparam int         CYCLE_LIMIT   = 250000;
   localparam int         PHASE_CHARS   = 175;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_FAIL_BLANK} row_kind_type;

   typedef struct packed {
      logic [7:0]   ch;
      logic         eob;
      row_kind_type kind;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow copy of the configuration registers
   logic [15:0] poly_reg;
   logic [7:0]  op_write_reg, op_read_reg, op_erase_reg, op_jump_reg;

   // Frame parser state
   logic [4:0]  char_pos;
   logic [7:0]  cmd_acc;
   logic [31:0] addr_acc;
   logic [7:0]  data_acc;
   logic [15:0] crc_rx;
   logic [15:0] crc_calc;
   logic [3:0]  nibble_hi;
   logic        decided;

   rsp_type expected_verdicts[$];
   int      errors        = 0;
   int      cycle_count   = 0;
   int      parsed_chars  = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   logic [15:0] phase_poly [1:4] = '{16'hFFFF, 16'h0000, 16'h8408, 16'h1021};
   // write, read, erase, jump opcodes packed high to low
   logic [31:0] phase_ops [1:4] = '{32'hFF00807F, 32'h5A5A5A5A, 32'hC4333333, 32'h10203040};

   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b1, ROW_FAIL_BLANK},   // bad start, buffer ends on the same character
      '{8'hFF, 1'b0, ROW_FAIL_BLANK},   // bad start
      '{"~",   1'b1, ROW_SILENT},       // trailing character, rearm
      '{"~",   1'b1, ROW_FAIL_BLANK},   // buffer ends right after the start
      '{"~",   1'b0, ROW_SILENT},
      '{"A",   1'b0, ROW_SILENT},
      '{"g",   1'b0, ROW_FAIL_BLANK},   // not a hex digit
      '{"0",   1'b1, ROW_SILENT},
      '{"~",   1'b0, ROW_PREDICT},
      '{"0",   1'b0, ROW_PREDICT},
      '{"1",   1'b0, ROW_PREDICT},
      '{"F",   1'b0, ROW_PREDICT},
      '{"f",   1'b0, ROW_PREDICT},
      '{"F",   1'b0, ROW_PREDICT},
      '{"f",   1'b0, ROW_PREDICT},
      '{"0",   1'b0, ROW_PREDICT},
      '{"0",   1'b0, ROW_PREDICT},
      '{"0",   1'b0, ROW_PREDICT},
      '{"9",   1'b0, ROW_PREDICT},
      '{"F",   1'b0, ROW_PREDICT},
      '{"f",   1'b0, ROW_PREDICT},
      '{8'h00, 1'b0, ROW_PREDICT},      // CRC digits filled in at start
      '{8'h00, 1'b0, ROW_PREDICT},
      '{8'h00, 1'b0, ROW_PREDICT},
      '{8'h00, 1'b1, ROW_PREDICT}
   };

   hex_command_frame_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      crc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (crc[0])
            crc = (crc >> 1) ^ poly_reg;
         else
            crc = crc >> 1;
      end
      return crc;
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // Letters come out in either case
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10)
         return 8'h30 + {4'h0, n};
      return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
   endfunction

   function automatic rsp_type verdict(logic [2:0] st, logic ok);
      return '{status: st, command_byte: cmd_acc, target_address: addr_acc,
               count_byte: data_acc, crc_ok: ok};
   endfunction

   task automatic rearm_parser();
      char_pos  = '0;
      cmd_acc   = '0;
      addr_acc  = '0;
      data_acc  = '0;
      crc_rx    = '0;
      crc_calc  = 16'hFFFF;
      nibble_hi = '0;
      decided   = 1'b0;
   endtask

   task automatic parse_char(input req_type item, output logic emitted, output rsp_type result);
      int         v;
      logic [7:0] b;
      logic [2:0] st;
      logic       ok;
      emitted = 1'b0;
      result  = '0;
      if (!decided) begin
         parsed_chars++;
         if (char_pos == 0) begin
            if (item.char_in != START_CHAR) begin
               result  = verdict(STATUS_FAIL, 1'b0);
               decided = 1'b1;
            end else begin
               crc_calc = crc_step(crc_calc, START_CHAR);
            end
         end else begin
            v = hex_val(item.char_in);
            if (v < 0) begin
               result  = verdict(STATUS_FAIL, 1'b0);
               decided = 1'b1;
            end else if (char_pos <= 5'd12) begin
               if (char_pos[0]) begin
                  nibble_hi = v[3:0];
               end else begin
                  b = {nibble_hi, v[3:0]};
                  if (char_pos == 5'd2)
                     cmd_acc = b;
                  else if (char_pos <= 5'd10)
                     addr_acc = {addr_acc[23:0], b};
                  else
                     data_acc = b;
                  crc_calc = crc_step(crc_calc, b);
               end
            end else begin
               crc_rx = {crc_rx[11:0], v[3:0]};
               if (char_pos >= LAST_POS) begin
                  ok = (crc_rx == crc_calc);
                  st = STATUS_FAIL;
                  // overlapping opcodes: write, then read, then erase, then jump
                  if (ok) begin
                     if (cmd_acc == op_write_reg)      st = STATUS_WRITE;
                     else if (cmd_acc == op_read_reg)  st = STATUS_READ;
                     else if (cmd_acc == op_erase_reg) st = STATUS_ERASE;
                     else if (cmd_acc == op_jump_reg)  st = STATUS_JUMP;
                  end
                  result  = verdict(st, ok);
                  decided = 1'b1;
               end
            end
         end
         if (!decided && char_pos < LAST_POS)
            char_pos++;
         if (!decided && item.end_of_buffer) begin
            result  = verdict(STATUS_FAIL, 1'b0);
            decided = 1'b1;
         end
         emitted = decided;
      end
      if (item.end_of_buffer)
         rearm_parser();
   endtask

   // Drive one transaction from a falling edge; return at the falling edge after acceptance
   task automatic send_char(input req_type item, input row_kind_type kind);
      logic    emitted;
      rsp_type result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      parse_char(item, emitted, result);
      case (kind)
         ROW_PREDICT:    if (emitted) expected_verdicts.push_back(result);
         ROW_FAIL_BLANK: expected_verdicts.push_back('{status: STATUS_FAIL, default: '0});
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Hold the sender until every result is in, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         CSR_POLY:     poly_reg     = val;
         CSR_OP_WRITE: op_write_reg = val[7:0];
         CSR_OP_READ:  op_read_reg  = val[7:0];
         CSR_OP_ERASE: op_erase_reg = val[7:0];
         CSR_OP_JUMP:  op_jump_reg  = val[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] poly, input logic [31:0] ops);
      write_reg(CSR_POLY,     poly);
      write_reg(CSR_OP_WRITE, {8'h00, ops[31:24]});
      write_reg(CSR_OP_READ,  {8'h00, ops[23:16]});
      write_reg(CSR_OP_ERASE, {8'h00, ops[15:8]});
      write_reg(CSR_OP_JUMP,  {8'h00, ops[7:0]});
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed frames with random content; the rest broken or noise
   task automatic send_random_buffer();
      req_type     chars[$];
      logic [7:0]  frame_bytes [6];
      logic [7:0]  cmd;
      logic [7:0]  c;
      logic [31:0] addr;
      logic [15:0] crc;
      logic [15:0] flip;
      int          kind;
      int          cut;
      case ($urandom_range(9))
         0, 1:    cmd = op_write_reg;
         2, 3:    cmd = op_read_reg;
         4, 5:    cmd = op_erase_reg;
         6, 7:    cmd = op_jump_reg;
         default: cmd = 8'($urandom);
      endcase
      case ($urandom_range(9))
         0:       addr = 32'h0000_0000;
         1:       addr = 32'hFFFF_FFFF;
         default: addr = $urandom;
      endcase
      frame_bytes[0] = cmd;
      frame_bytes[1] = addr[31:24];
      frame_bytes[2] = addr[23:16];
      frame_bytes[3] = addr[15:8];
      frame_bytes[4] = addr[7:0];
      frame_bytes[5] = 8'($urandom);
      crc = crc_step(16'hFFFF, START_CHAR);
      foreach (frame_bytes[i])
         crc = crc_step(crc, frame_bytes[i]);
      if ($urandom_range(99) < 15) begin
         flip = 16'($urandom_range(65535, 1));
         crc  = crc ^ flip;
      end
      chars.push_back('{START_CHAR, 1'b0});
      foreach (frame_bytes[i]) begin
         chars.push_back('{hex_char(frame_bytes[i][7:4]), 1'b0});
         chars.push_back('{hex_char(frame_bytes[i][3:0]), 1'b0});
      end
      for (int i = 3; i >= 0; i--)
         chars.push_back('{hex_char(crc[4*i +: 4]), 1'b0});

      kind = $urandom_range(99);
      if (kind < 70) begin
         if ($urandom_range(1)) begin
            repeat ($urandom_range(3, 1)) begin
               c = 8'($urandom);
               chars.push_back('{c, 1'b0});
            end
         end
      end else if (kind < 80) begin
         cut = $urandom_range(16, 1);
         while (chars.size() > cut)
            void'(chars.pop_back());
      end else if (kind < 90) begin
         cut = $urandom_range(16, 1);
         do
            c = 8'($urandom);
         while (hex_val(c) >= 0);
         chars[cut].char_in = c;
         while (chars.size() > cut + 1)
            void'(chars.pop_back());
         repeat ($urandom_range(2)) begin
            c = 8'($urandom);
            chars.push_back('{c, 1'b0});
         end
      end else begin
         chars.delete();
         repeat ($urandom_range(4, 1)) begin
            c = 8'($urandom);
            chars.push_back('{c, $urandom_range(1) == 1});
         end
         if ($urandom_range(3) == 0)
            chars[0].char_in = START_CHAR;
      end
      chars[chars.size()-1].end_of_buffer = 1'b1;
      foreach (chars[i])
         send_char(chars[i], ROW_PREDICT);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t ns: result with none expected, expected nothing, got %p",
                     $time, rsp_data);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("command_byte", 32'(want.command_byte),
                        32'(rsp_data.command_byte));
            check_field("target_address", want.target_address, rsp_data.target_address);
            check_field("count_byte", 32'(want.count_byte), 32'(rsp_data.count_byte));
            check_field("crc_ok", 32'(want.crc_ok), 32'(rsp_data.crc_ok));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] crc;
      int          phase_start;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      poly_reg     = POLY_RESET;
      op_write_reg = OP_WRITE_RESET;
      op_read_reg  = OP_READ_RESET;
      op_erase_reg = OP_ERASE_RESET;
      op_jump_reg  = OP_JUMP_RESET;
      rearm_parser();

      // Fill in the CRC digits of the directed write frame
      crc = crc_step(16'hFFFF, START_CHAR);
      crc = crc_step(crc, 8'h01);
      crc = crc_step(crc, 8'hFF);
      crc = crc_step(crc, 8'hFF);
      crc = crc_step(crc, 8'h00);
      crc = crc_step(crc, 8'h09);
      crc = crc_step(crc, 8'hFF);
      for (int i = 0; i < 4; i++)
         directed_rows[21+i].ch = hex_char(crc[12-4*i +: 4]);

      send_idle_pct = 12;
      recv_idle_pct = 58;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_char('{directed_rows[i].ch, directed_rows[i].eob}, directed_rows[i].kind);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         if (p == 5)
            apply_settings(16'($urandom), $urandom);
         else if (p > 0)
            apply_settings(phase_poly[p], phase_ops[p]);
         case (p / 2)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = parsed_chars;
         while (parsed_chars - phase_start < PHASE_CHARS) begin
            send_random_buffer();
            if ($urandom_range(39) == 0)
               wait_idle();
         end
         wait_idle();
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
